FILE: src/bilinear_texture_sampler_unit_macros.svh
// Assertion macros shared by the texture sampler modules.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH

// prop must hold at every edge outside reset
`define BTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// cond at one edge implies res at the next edge
`define BTS_ASSERT_NEXT(label, cond, res, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (res)) \
    else $error(msg);

`endif

FILE: src/bts_pkg.sv
// Shared constants and codes for the bilinear texture sampler.
// No dependencies.
`default_nettype none
package bts_pkg;

  localparam int COORD_W   = 16;
  localparam int CH_W      = 8;
  localparam int TEXEL_W   = 3 * CH_W;
  localparam int IDX_W     = 16;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 8;
  localparam int OUT_W     = 16;
  localparam int QDEPTH    = 4;
  localparam int NSLOT     = 4;

  localparam logic [CFG_W-1:0] TEX_DIM_RESET = CFG_W'(256);

  typedef enum logic {
    REQ_WRITE  = 1'b0,
    REQ_SAMPLE = 1'b1
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEX_WIDTH  = 8'd0,
    CFG_TEX_HEIGHT = 8'd1
  } cfg_reg_e;

endpackage
`default_nettype wire

FILE: src/bts_front.sv
// Front end: config registers, coordinate scaling, index formation and clamping.
// Depends on bts_pkg.
`default_nettype none
module bts_front #(
  parameter int MAX_TEXELS      = 65536,
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bts_pkg::CFG_W-1:0]       cfg_data_i,
  input  logic                            valid_i,
  output logic                            ready_o,
  input  logic                            req_type_i,
  input  logic [bts_pkg::IDX_W-1:0]       texel_index_i,
  input  logic [bts_pkg::TEXEL_W-1:0]     texel_i,
  input  logic [bts_pkg::COORD_W-1:0]     u_coord_i,
  input  logic [bts_pkg::COORD_W-1:0]     v_coord_i,
  output logic                            q_valid_o,
  input  logic                            q_ready_i,
  output logic                            q_type_o,
  output logic                            q_wen_o,
  output logic [$clog2(MAX_TEXELS)-1:0]   q_waddr_o,
  output logic [bts_pkg::TEXEL_W-1:0]     q_wdata_o,
  output logic [$clog2(MAX_TEXELS)-1:0]   q_addr_o [bts_pkg::NSLOT],
  output logic [COORD_FRAC_BITS-1:0]      q_ur_o,
  output logic [COORD_FRAC_BITS-1:0]      q_vr_o
);
  import bts_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int AW  = $clog2(MAX_TEXELS);
  localparam int LW  = $clog2(MAX_TEXELS + 1);
  localparam int IXW = COORD_W + CFG_W + 1;
  localparam int XW  = IXW - F;
  localparam int IW  = XW + CFG_W + 2;
  localparam int PW  = 2 * CFG_W;
  localparam int CW  = (LW > PW) ? LW : PW;
  localparam logic [IXW-1:0] HALF = IXW'(1) << (F - 1);

  logic [CFG_W-1:0] tex_w_q, tex_h_q;
  logic [LW-1:0]    lim_q;
  logic [PW-1:0]    dim_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_w_q <= TEX_DIM_RESET;
      tex_h_q <= TEX_DIM_RESET;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CFG_TEX_WIDTH)  tex_w_q <= cfg_data_i;
      if (cfg_index_i == CFG_TEX_HEIGHT) tex_h_q <= cfg_data_i;
    end
  end

  assign dim_prod = PW'(tex_w_q) * PW'(tex_h_q);

  always_ff @(posedge clk_i) begin
    lim_q <= (CW'(dim_prod) > CW'(MAX_TEXELS)) ? LW'(MAX_TEXELS) : LW'(dim_prod);
  end

  // stage 1: magnitude times dimension
  logic             f1_v_q, f2_v_q;
  logic             f1_type_q, f1_wen_q;
  logic [AW-1:0]    f1_waddr_q;
  logic [TEXEL_W-1:0] f1_wdata_q;
  logic [IXW-1:0]   f1_ix_q, f1_iy_q;
  logic [COORD_W-1:0] mag_u, mag_v;
  logic             f2_ready, push;

  assign mag_u = u_coord_i[COORD_W-1] ? (~u_coord_i + COORD_W'(1)) : u_coord_i;
  assign mag_v = v_coord_i[COORD_W-1] ? (~v_coord_i + COORD_W'(1)) : v_coord_i;

  assign push     = f2_v_q && q_ready_i;
  assign f2_ready = !f2_v_q || push;
  assign ready_o  = !f1_v_q || f2_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
    end else begin
      if (ready_o) f1_v_q <= valid_i;
      if (f2_ready) f2_v_q <= f1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      f1_type_q  <= req_type_i;
      f1_wen_q   <= CW'(texel_index_i) < CW'(MAX_TEXELS);
      f1_waddr_q <= AW'(texel_index_i);
      f1_wdata_q <= texel_i;
      f1_ix_q    <= IXW'(mag_u) * IXW'(tex_w_q) + HALF;
      f1_iy_q    <= IXW'(mag_v) * IXW'(tex_h_q) + HALF;
    end
  end

  // stage 2: row base
  logic             f2_type_q, f2_wen_q;
  logic [AW-1:0]    f2_waddr_q;
  logic [TEXEL_W-1:0] f2_wdata_q;
  logic [IW-1:0]    f2_row_q;
  logic [XW-1:0]    f2_x_q;
  logic [F-1:0]     f2_ur_q, f2_vr_q;

  always_ff @(posedge clk_i) begin
    if (f1_v_q && f2_ready) begin
      f2_type_q  <= f1_type_q;
      f2_wen_q   <= f1_wen_q;
      f2_waddr_q <= f1_waddr_q;
      f2_wdata_q <= f1_wdata_q;
      f2_row_q   <= IW'(f1_iy_q[IXW-1:F]) * IW'(tex_w_q);
      f2_x_q     <= f1_ix_q[IXW-1:F];
      f2_ur_q    <= f1_ix_q[F-1:0];
      f2_vr_q    <= f1_iy_q[F-1:0];
    end
  end

  function automatic logic [AW-1:0] clamp_idx(input logic [IW-1:0] idx,
                                              input logic [LW-1:0] lim);
    logic [LW-1:0] last;
    last = lim - LW'(1);
    if (lim == '0) return '0;
    else if (idx >= IW'(lim)) return AW'(last);
    else return AW'(idx);
  endfunction

  logic [IW-1:0] i_lt, i_lb;

  assign i_lt = f2_row_q + IW'(f2_x_q);
  assign i_lb = i_lt + IW'(tex_w_q);

  assign q_valid_o   = f2_v_q;
  assign q_type_o    = f2_type_q;
  assign q_wen_o     = f2_wen_q;
  assign q_waddr_o   = f2_waddr_q;
  assign q_wdata_o   = f2_wdata_q;
  assign q_addr_o[0] = clamp_idx(i_lt, lim_q);
  assign q_addr_o[1] = clamp_idx(i_lt + IW'(1), lim_q);
  assign q_addr_o[2] = clamp_idx(i_lb, lim_q);
  assign q_addr_o[3] = clamp_idx(i_lb + IW'(1), lim_q);
  assign q_ur_o      = f2_ur_q;
  assign q_vr_o      = f2_vr_q;

endmodule
`default_nettype wire

FILE: src/bts_queue.sv
// Small request queue between front end and texel fetch.
// Depends on bts_pkg and the assertion macro header.
`default_nettype none
`include "bilinear_texture_sampler_unit_macros.svh"
module bts_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output logic [DATA_W-1:0] pop_data_o
);
  import bts_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] data_q [DEPTH];
  logic [PTRW-1:0]   wp_q, rp_q;
  logic [CNTW-1:0]   cnt_q;
  logic              push, pop;

  assign push_ready_o = cnt_q != CNTW'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = data_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= (wp_q == PTRW'(DEPTH - 1)) ? '0 : wp_q + PTRW'(1);
      if (pop)  rp_q <= (rp_q == PTRW'(DEPTH - 1)) ? '0 : rp_q + PTRW'(1);
      if (push && !pop) cnt_q <= cnt_q + CNTW'(1);
      else if (pop && !push) cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) data_q[wp_q] <= push_data_i;
  end

  `BTS_ASSERT(a_q_count, cnt_q <= CNTW'(DEPTH), "queue count past depth")

endmodule
`default_nettype wire

FILE: src/bts_back.sv
// Texel fetch: single-port texel memory, write handling and four-read sequencer.
// Depends on bts_pkg and the assertion macro header.
`default_nettype none
`include "bilinear_texture_sampler_unit_macros.svh"
module bts_back #(
  parameter int MAX_TEXELS      = 65536,
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  output logic                            q_ready_o,
  input  logic                            q_type_i,
  input  logic                            q_wen_i,
  input  logic [$clog2(MAX_TEXELS)-1:0]   q_waddr_i,
  input  logic [bts_pkg::TEXEL_W-1:0]     q_wdata_i,
  input  logic [$clog2(MAX_TEXELS)-1:0]   q_addr_i [bts_pkg::NSLOT],
  input  logic [COORD_FRAC_BITS-1:0]      q_ur_i,
  input  logic [COORD_FRAC_BITS-1:0]      q_vr_i,
  input  logic                            blend_free_i,
  output logic                            pkt_valid_o,
  output logic [bts_pkg::TEXEL_W-1:0]     lt_o,
  output logic [bts_pkg::TEXEL_W-1:0]     rt_o,
  output logic [bts_pkg::TEXEL_W-1:0]     lb_o,
  output logic [bts_pkg::TEXEL_W-1:0]     rb_o,
  output logic [COORD_FRAC_BITS-1:0]      ur_o,
  output logic [COORD_FRAC_BITS-1:0]      vr_o
);
  import bts_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int AW = $clog2(MAX_TEXELS);
  localparam int SW = $clog2(NSLOT);
  localparam logic [SW-1:0] LAST_SLOT = SW'(NSLOT - 1);

  logic [TEXEL_W-1:0] mem_q [MAX_TEXELS];
  logic [TEXEL_W-1:0] rd_q;
  logic [TEXEL_W-1:0] buf_q [NSLOT-1];

  logic               cur_v_q, cur_type_q, cur_wen_q;
  logic [AW-1:0]      cur_waddr_q;
  logic [TEXEL_W-1:0] cur_wdata_q;
  logic [AW-1:0]      cur_addr_q [NSLOT];
  logic [F-1:0]       cur_ur_q, cur_vr_q;
  logic [SW-1:0]      slot_q, rd_slot_q;
  logic               rd_v_q;
  logic [F-1:0]       rd_ur_q, rd_vr_q;

  logic          issue, wr, cur_done, pop;
  logic [AW-1:0] mem_addr;

  always_comb begin
    issue    = cur_v_q && (cur_type_q == REQ_SAMPLE) &&
               ((slot_q != LAST_SLOT) || blend_free_i);
    wr       = cur_v_q && (cur_type_q == REQ_WRITE) && cur_wen_q;
    cur_done = cur_v_q && ((cur_type_q == REQ_WRITE) || (issue && slot_q == LAST_SLOT));
    q_ready_o = !cur_v_q || cur_done;
    pop      = q_valid_i && q_ready_o;
    mem_addr = wr ? cur_waddr_q : cur_addr_q[slot_q];
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[mem_addr] <= cur_wdata_q;
    rd_q <= mem_q[mem_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_v_q   <= 1'b0;
      slot_q    <= '0;
      rd_v_q    <= 1'b0;
      rd_slot_q <= '0;
    end else begin
      if (pop) begin
        cur_v_q <= 1'b1;
        slot_q  <= '0;
      end else if (cur_done) begin
        cur_v_q <= 1'b0;
      end else if (issue) begin
        slot_q <= slot_q + SW'(1);
      end
      rd_v_q    <= issue;
      rd_slot_q <= slot_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_type_q  <= q_type_i;
      cur_wen_q   <= q_wen_i;
      cur_waddr_q <= q_waddr_i;
      cur_wdata_q <= q_wdata_i;
      cur_addr_q  <= q_addr_i;
      cur_ur_q    <= q_ur_i;
      cur_vr_q    <= q_vr_i;
    end
    if (issue) begin
      rd_ur_q <= cur_ur_q;
      rd_vr_q <= cur_vr_q;
    end
    if (rd_v_q && rd_slot_q != LAST_SLOT) buf_q[rd_slot_q] <= rd_q;
  end

  assign pkt_valid_o = rd_v_q && (rd_slot_q == LAST_SLOT);
  assign lt_o = buf_q[0];
  assign rt_o = buf_q[1];
  assign lb_o = buf_q[2];
  assign rb_o = rd_q;
  assign ur_o = rd_ur_q;
  assign vr_o = rd_vr_q;

  `BTS_ASSERT_NEXT(a_last_read_hands_off, issue && slot_q == LAST_SLOT, pkt_valid_o, "last read lost")

endmodule
`default_nettype wire

FILE: src/bts_blend.sv
// Bilinear blend: horizontal lerp stage, vertical lerp into the output register.
// Depends on bts_pkg and the assertion macro header.
`default_nettype none
`include "bilinear_texture_sampler_unit_macros.svh"
module bts_blend #(
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [bts_pkg::TEXEL_W-1:0] lt_i,
  input  logic [bts_pkg::TEXEL_W-1:0] rt_i,
  input  logic [bts_pkg::TEXEL_W-1:0] lb_i,
  input  logic [bts_pkg::TEXEL_W-1:0] rb_i,
  input  logic [COORD_FRAC_BITS-1:0]  ur_i,
  input  logic [COORD_FRAC_BITS-1:0]  vr_i,
  output logic                        free_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [bts_pkg::OUT_W-1:0]   red_out_o,
  output logic [bts_pkg::OUT_W-1:0]   green_out_o,
  output logic [bts_pkg::OUT_W-1:0]   blue_out_o
);
  import bts_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int TW  = F + CH_W + 1;
  localparam int ACW = 2 * F + CH_W + 1;
  localparam logic [F:0] ONE = (F + 1)'(1) << F;

  logic          s1_v_q, o_v_q, o_ready, s1_adv;
  logic [TW-1:0] top_q [3];
  logic [TW-1:0] bot_q [3];
  logic [F-1:0]  s1_vr_q;
  logic [OUT_W-1:0] out_q [3];
  logic [F:0]    uw, vw;
  logic [TW-1:0] top_d [3];
  logic [TW-1:0] bot_d [3];
  logic [ACW-1:0] acc [3];

  assign o_ready = !o_v_q || ready_i;
  assign s1_adv  = s1_v_q && o_ready;
  assign free_o  = !s1_v_q || o_ready;
  assign uw      = ONE - (F + 1)'(ur_i);
  assign vw      = ONE - (F + 1)'(s1_vr_q);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      top_d[c] = TW'(lt_i[CH_W*(2-c) +: CH_W]) * TW'(uw) +
                 TW'(rt_i[CH_W*(2-c) +: CH_W]) * TW'(ur_i);
      bot_d[c] = TW'(lb_i[CH_W*(2-c) +: CH_W]) * TW'(uw) +
                 TW'(rb_i[CH_W*(2-c) +: CH_W]) * TW'(ur_i);
      acc[c]   = ACW'(top_q[c]) * ACW'(vw) + ACW'(bot_q[c]) * ACW'(s1_vr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      o_v_q  <= 1'b0;
    end else begin
      if (in_valid_i) s1_v_q <= 1'b1;
      else if (s1_adv) s1_v_q <= 1'b0;
      if (o_ready) o_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      top_q   <= top_d;
      bot_q   <= bot_d;
      s1_vr_q <= vr_i;
    end
    if (s1_adv) begin
      for (int c = 0; c < 3; c++) out_q[c] <= acc[c][2*F+CH_W-1 -: OUT_W];
    end
  end

  assign valid_o     = o_v_q;
  assign red_out_o   = out_q[0];
  assign green_out_o = out_q[1];
  assign blue_out_o  = out_q[2];

  `BTS_ASSERT(a_blend_no_overrun, !in_valid_i || !s1_v_q || o_ready, "blend stage overrun")

endmodule
`default_nettype wire

FILE: src/bilinear_texture_sampler_unit.sv
// Top level of the bilinear RGB8 texture sampler.
// Depends on bts_pkg, bts_front, bts_queue, bts_back and bts_blend.
//
// Write requests store one texel in the fetch stage; sample requests read four
// texels from the single-port texel memory, one per cycle unless the last read
// waits for the blend stage to be free, so the fetch port limits the sample rate.
// The next request is taken as the last read of a sample issues. Texels read
// before being written return undefined data. Config writes take effect at
// once; issue them only with no request in flight.
`default_nettype none
module bilinear_texture_sampler_unit #(
  parameter int MAX_TEXELS      = 65536,
  parameter int COORD_FRAC_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bts_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [bts_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic                          req_type_i,
  input  logic [bts_pkg::IDX_W-1:0]     texel_index_i,
  input  logic [bts_pkg::CH_W-1:0]      red_in_i,
  input  logic [bts_pkg::CH_W-1:0]      green_in_i,
  input  logic [bts_pkg::CH_W-1:0]      blue_in_i,
  input  logic signed [bts_pkg::COORD_W-1:0] u_coord_i,
  input  logic signed [bts_pkg::COORD_W-1:0] v_coord_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output logic [bts_pkg::OUT_W-1:0]     red_out_o,
  output logic [bts_pkg::OUT_W-1:0]     green_out_o,
  output logic [bts_pkg::OUT_W-1:0]     blue_out_o
);
  import bts_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int AW = $clog2(MAX_TEXELS);
  localparam int EW = 2 + AW + TEXEL_W + NSLOT * AW + 2 * F;

  logic               fq_valid, fq_ready, fq_type, fq_wen;
  logic [AW-1:0]      fq_waddr;
  logic [TEXEL_W-1:0] fq_wdata;
  logic [AW-1:0]      fq_addr [NSLOT];
  logic [F-1:0]       fq_ur, fq_vr;

  logic               bq_valid, bq_ready, bq_type, bq_wen;
  logic [AW-1:0]      bq_waddr;
  logic [TEXEL_W-1:0] bq_wdata;
  logic [AW-1:0]      bq_addr [NSLOT];
  logic [F-1:0]       bq_ur, bq_vr;

  logic [EW-1:0]      push_data, pop_data;

  logic               pkt_valid, blend_free;
  logic [TEXEL_W-1:0] lt, rt, lb, rb;
  logic [F-1:0]       pkt_ur, pkt_vr;

  assign cfg_ready_o = 1'b1;

  bts_front #(
    .MAX_TEXELS      (MAX_TEXELS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .valid_i       (valid_i),
    .ready_o       (ready_o),
    .req_type_i    (req_type_i),
    .texel_index_i (texel_index_i),
    .texel_i       ({red_in_i, green_in_i, blue_in_i}),
    .u_coord_i     (u_coord_i),
    .v_coord_i     (v_coord_i),
    .q_valid_o     (fq_valid),
    .q_ready_i     (fq_ready),
    .q_type_o      (fq_type),
    .q_wen_o       (fq_wen),
    .q_waddr_o     (fq_waddr),
    .q_wdata_o     (fq_wdata),
    .q_addr_o      (fq_addr),
    .q_ur_o        (fq_ur),
    .q_vr_o        (fq_vr)
  );

  assign push_data = {fq_type, fq_wen, fq_waddr, fq_wdata,
                      fq_addr[0], fq_addr[1], fq_addr[2], fq_addr[3], fq_ur, fq_vr};

  bts_queue #(
    .DATA_W (EW),
    .DEPTH  (QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (bq_valid),
    .pop_ready_i  (bq_ready),
    .pop_data_o   (pop_data)
  );

  assign {bq_type, bq_wen, bq_waddr, bq_wdata,
          bq_addr[0], bq_addr[1], bq_addr[2], bq_addr[3], bq_ur, bq_vr} = pop_data;

  bts_back #(
    .MAX_TEXELS      (MAX_TEXELS),
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (bq_valid),
    .q_ready_o    (bq_ready),
    .q_type_i     (bq_type),
    .q_wen_i      (bq_wen),
    .q_waddr_i    (bq_waddr),
    .q_wdata_i    (bq_wdata),
    .q_addr_i     (bq_addr),
    .q_ur_i       (bq_ur),
    .q_vr_i       (bq_vr),
    .blend_free_i (blend_free),
    .pkt_valid_o  (pkt_valid),
    .lt_o         (lt),
    .rt_o         (rt),
    .lb_o         (lb),
    .rb_o         (rb),
    .ur_o         (pkt_ur),
    .vr_o         (pkt_vr)
  );

  bts_blend #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS)
  ) u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pkt_valid),
    .lt_i        (lt),
    .rt_i        (rt),
    .lb_i        (lb),
    .rb_i        (rb),
    .ur_i        (pkt_ur),
    .vr_i        (pkt_vr),
    .free_o      (blend_free),
    .valid_o     (valid_o),
    .ready_i     (ready_i),
    .red_out_o   (red_out_o),
    .green_out_o (green_out_o),
    .blue_out_o  (blue_out_o)
  );

endmodule
`default_nettype wire
